FILE: hdl/dpcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcp_pkg
// Shared types and constants for the debounced press count pulser.
// ----------------------------------------------------------------------------
package dpcp_pkg;

    localparam int CFG_W        = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int COUNT_W      = 8;
    localparam int TIMER_W      = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_W-1:0]       cfg_word_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [TIMER_W-1:0]     timer_t;
    typedef logic [1:0]             press_code_t;

    localparam cfg_index_t REG_WINDOW_TICKS     = 2'd0;
    localparam cfg_index_t REG_HOLD_TICKS_LONG  = 2'd1;
    localparam cfg_index_t REG_HOLD_TICKS_SHORT = 2'd2;

    localparam cfg_word_t RESET_WINDOW_TICKS     = 16'd500;
    localparam cfg_word_t RESET_HOLD_TICKS_LONG  = 16'd500;
    localparam cfg_word_t RESET_HOLD_TICKS_SHORT = 16'd250;

    localparam press_code_t CODE_NONE  = 2'd0;
    localparam press_code_t CODE_TWO   = 2'd1;
    localparam press_code_t CODE_THREE = 2'd2;
    localparam press_code_t CODE_FOUR  = 2'd3;

    localparam count_t COUNT_MAX   = 8'hFF;
    localparam count_t COUNT_TWO   = 8'd2;
    localparam count_t COUNT_FOUR  = 8'd4;
    localparam timer_t TIMER_MAX   = 16'hFFFF;

    typedef struct packed {
        cfg_word_t window_ticks;
        cfg_word_t hold_ticks_long;
        cfg_word_t hold_ticks_short;
    } cfg_t;

    typedef struct packed {
        logic        holding;
        press_code_t shown;
    } press_status_t;

endpackage

FILE: hdl/dpcp_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcp_debounce
// Shift-register debouncer: clean level follows a run of equal samples.
// ----------------------------------------------------------------------------
module dpcp_debounce #(
    parameter int DEBOUNCE_SAMPLES = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic raw_level,
    output logic clean_level,
    output logic clean_next
);

    logic [DEBOUNCE_SAMPLES-1:0] history_reg;
    logic [DEBOUNCE_SAMPLES-1:0] history_next;
    logic                        clean_reg;

    always_comb
    begin
        history_next = {history_reg[DEBOUNCE_SAMPLES-2:0], raw_level};
        if (&history_next)
        begin
            clean_next = 1'b1;
        end
        else if (~|history_next)
        begin
            clean_next = 1'b0;
        end
        else
        begin
            clean_next = clean_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= '0;
            clean_reg   <= 1'b0;
        end
        else if (step)
        begin
            history_reg <= history_next;
            clean_reg   <= clean_next;
        end
    end

    assign clean_level = clean_reg;

endmodule

FILE: hdl/dpcp_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcp_press
// Edge counter, window timer and pulse hold for one tick per beat.
// ----------------------------------------------------------------------------
module dpcp_press (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   rise,
    input  dpcp_pkg::cfg_t         cfg,
    output dpcp_pkg::press_status_t status
);

    dpcp_pkg::count_t      count_reg,  count_next,  count_mid;
    dpcp_pkg::timer_t      timer_reg,  timer_next,  timer_mid;
    dpcp_pkg::timer_t      hold_reg,   hold_next;
    dpcp_pkg::press_code_t active_reg, active_next;
    dpcp_pkg::press_code_t shown;
    dpcp_pkg::cfg_word_t   hold_len;
    dpcp_pkg::timer_t      hold_left;

    always_comb
    begin
        count_next  = count_reg;
        timer_next  = timer_reg;
        hold_next   = hold_reg;
        active_next = active_reg;
        shown       = dpcp_pkg::CODE_NONE;
        count_mid   = count_reg;
        timer_mid   = timer_reg;
        hold_len    = cfg.hold_ticks_long;
        hold_left   = hold_len - 16'd1;

        if (hold_reg != '0)
        begin
            shown     = active_reg;
            hold_next = hold_reg - 16'd1;
            if (hold_next == '0)
            begin
                active_next = dpcp_pkg::CODE_NONE;
            end
        end
        else
        begin
            if (rise)
            begin
                if (count_reg != dpcp_pkg::COUNT_MAX)
                begin
                    count_mid = count_reg + 8'd1;
                end
                timer_mid = '0;
            end
            if (count_mid != '0 && timer_mid != dpcp_pkg::TIMER_MAX)
            begin
                timer_mid = timer_mid + 16'd1;
            end

            count_next = count_mid;
            timer_next = timer_mid;

            if (timer_mid >= cfg.window_ticks)
            begin
                if (count_mid == dpcp_pkg::COUNT_FOUR)
                begin
                    hold_len = cfg.hold_ticks_short;
                end
                hold_left = hold_len - 16'd1;
                if (count_mid >= dpcp_pkg::COUNT_TWO && count_mid <= dpcp_pkg::COUNT_FOUR
                    && hold_len != '0)
                begin
                    shown       = dpcp_pkg::press_code_t'(count_mid - 8'd1);
                    hold_next   = hold_left;
                    active_next = (hold_left != '0) ? shown : dpcp_pkg::CODE_NONE;
                end
                count_next = '0;
                timer_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            timer_reg  <= '0;
            hold_reg   <= '0;
            active_reg <= dpcp_pkg::CODE_NONE;
        end
        else if (step)
        begin
            count_reg  <= count_next;
            timer_reg  <= timer_next;
            hold_reg   <= hold_next;
            active_reg <= active_next;
        end
    end

    assign status.holding = (hold_reg != '0);
    assign status.shown   = shown;

endmodule

FILE: hdl/debounced_press_count_pulser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_press_count_pulser
// Debounces a sampled pin, counts presses in a window and pulses an output.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat (in_valid/in_stall, raw_level) is one tick of the pin.
//   Each accepted beat yields exactly one output beat (out_valid/out_stall)
//   carrying out_two_press, out_three_press and out_four_press.
//   The result of a beat accepted at one edge is presented from the next
//   edge on. Throughput is one beat per cycle while the receiver does not
//   stall; the whole tick update is a single combinational pass into the
//   state and the output register.
//   While the receiver stalls with a result pending, in_stall is raised and
//   the held result stays unchanged; once it is taken, a new beat may be
//   accepted in the same cycle.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle;
//   index 3 is ignored.
//   Reset clears the debouncer, counter, timer and hold, empties the output
//   register and loads window 500, long hold 500 and short hold 250 ticks.
// ----------------------------------------------------------------------------
module debounced_press_count_pulser #(
    parameter int DEBOUNCE_SAMPLES = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         raw_level,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         out_two_press,
    output logic                         out_three_press,
    output logic                         out_four_press,
    input  logic                         cfg_we,
    input  dpcp_pkg::cfg_index_t         cfg_index,
    input  dpcp_pkg::cfg_word_t          cfg_data
);

    dpcp_pkg::cfg_t          cfg_reg;
    dpcp_pkg::press_status_t status;
    dpcp_pkg::press_code_t   code_reg;
    logic                    out_valid_reg;
    logic                    accept;
    logic                    step;
    logic                    clean_level;
    logic                    clean_next;
    logic                    rise;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign step     = accept && !status.holding;
    assign rise     = !clean_level && clean_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ticks     <= dpcp_pkg::RESET_WINDOW_TICKS;
            cfg_reg.hold_ticks_long  <= dpcp_pkg::RESET_HOLD_TICKS_LONG;
            cfg_reg.hold_ticks_short <= dpcp_pkg::RESET_HOLD_TICKS_SHORT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dpcp_pkg::REG_WINDOW_TICKS:     cfg_reg.window_ticks     <= cfg_data;
                dpcp_pkg::REG_HOLD_TICKS_LONG:  cfg_reg.hold_ticks_long  <= cfg_data;
                dpcp_pkg::REG_HOLD_TICKS_SHORT: cfg_reg.hold_ticks_short <= cfg_data;
                default: ;
            endcase
        end
    end

    dpcp_debounce #(
        .DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
    ) u_debounce (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .raw_level  (raw_level),
        .clean_level(clean_level),
        .clean_next (clean_next)
    );

    dpcp_press u_press (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .rise  (rise),
        .cfg   (cfg_reg),
        .status(status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= status.shown;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_two_press   = out_valid_reg && (code_reg == dpcp_pkg::CODE_TWO);
    assign out_three_press = out_valid_reg && (code_reg == dpcp_pkg::CODE_THREE);
    assign out_four_press  = out_valid_reg && (code_reg == dpcp_pkg::CODE_FOUR);

    a_one_output: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({out_two_press, out_three_press, out_four_press}))
        else $error("more than one press output high");

    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted beat produced no result");

    a_frozen_debounce: assert property (@(posedge clk) disable iff (!rst_n)
        (!accept || status.holding) |=> $stable(clean_level))
        else $error("debouncer moved without a sampled tick");

endmodule

FILE: sim/debounced_press_count_pulser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_press_count_pulser_test
// Self-checking bench for the debounced press count pulser. Pin samples are
// sent as beats, shaped mostly as press trains of one to seven presses and
// partly as raw noise. A tick-accurate tracker predicts every output beat,
// and each accepted beat is compared against it field by field. Windows and
// holds are set to zero, one and small random values, and the widest window
// is cut short by lowering it under a running timer. Both sides idle in turn.
// ----------------------------------------------------------------------------
module debounced_press_count_pulser_test;

    localparam int                   HIST_W       = 8;
    localparam dpcp_pkg::cfg_index_t REG_UNUSED   = 2'd3;
    localparam int                   CYCLE_LIMIT  = 50_000;
    localparam int                   RANDOM_ITEMS = 60;

    class pulse_tracker;
        dpcp_pkg::cfg_t          cfg;
        logic [HIST_W-1:0]       history;
        logic                    clean;
        logic                    last_clean;
        dpcp_pkg::count_t        presses;
        dpcp_pkg::timer_t        timer;
        dpcp_pkg::timer_t        hold_left;
        dpcp_pkg::press_code_t   active;
        dpcp_pkg::press_code_t   expected_pulses[$];
        int                      errors;
        int                      live_ticks;
        int                      checked;
        int                      pulses[4];

        function new();
            cfg.window_ticks     = dpcp_pkg::RESET_WINDOW_TICKS;
            cfg.hold_ticks_long  = dpcp_pkg::RESET_HOLD_TICKS_LONG;
            cfg.hold_ticks_short = dpcp_pkg::RESET_HOLD_TICKS_SHORT;
            history    = '0;
            clean      = 1'b0;
            last_clean = 1'b0;
            presses    = '0;
            timer      = '0;
            hold_left  = '0;
            active     = dpcp_pkg::CODE_NONE;
            errors     = 0;
            live_ticks = 0;
            checked    = 0;
            foreach (pulses[i]) pulses[i] = 0;
        endfunction

        function void write_reg(dpcp_pkg::cfg_index_t idx, dpcp_pkg::cfg_word_t value);
            case (idx)
                dpcp_pkg::REG_WINDOW_TICKS:     cfg.window_ticks     = value;
                dpcp_pkg::REG_HOLD_TICKS_LONG:  cfg.hold_ticks_long  = value;
                dpcp_pkg::REG_HOLD_TICKS_SHORT: cfg.hold_ticks_short = value;
                default: ;
            endcase
        endfunction

        function bit holding();
            return hold_left != 0;
        endfunction

        function bit busy();
            return (hold_left != 0) || (presses != 0);
        endfunction

        function int pending();
            return expected_pulses.size();
        endfunction

        function dpcp_pkg::press_code_t predict_tick(logic lvl);
            dpcp_pkg::press_code_t shown;
            dpcp_pkg::cfg_word_t   hold;
            if (hold_left != 0)
            begin
                shown = active;
                hold_left--;
                if (hold_left == 0)
                    active = dpcp_pkg::CODE_NONE;
                return shown;
            end
            live_ticks++;
            history = {history[HIST_W-2:0], lvl};
            if (history == {HIST_W{1'b1}})
                clean = 1'b1;
            else if (history == '0)
                clean = 1'b0;
            if (!last_clean && clean)
            begin
                if (presses < dpcp_pkg::COUNT_MAX)
                    presses++;
                timer = '0;
            end
            if (presses != 0 && timer < dpcp_pkg::TIMER_MAX)
                timer++;
            shown = dpcp_pkg::CODE_NONE;
            if (timer >= cfg.window_ticks)
            begin
                if (presses >= dpcp_pkg::COUNT_TWO && presses <= dpcp_pkg::COUNT_FOUR)
                begin
                    hold = (presses == dpcp_pkg::COUNT_FOUR) ? cfg.hold_ticks_short
                                                             : cfg.hold_ticks_long;
                    if (hold != 0)
                    begin
                        shown     = dpcp_pkg::press_code_t'(presses - 1'b1);
                        hold_left = hold - 1'b1;
                        active    = (hold_left != 0) ? shown : dpcp_pkg::CODE_NONE;
                        pulses[shown]++;
                    end
                end
                timer   = '0;
                presses = '0;
            end
            last_clean = clean;
            return shown;
        endfunction

        function void note_tick(logic lvl);
            expected_pulses.push_back(predict_tick(lvl));
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at beat %0d: %s", checked, msg);
        endtask

        task check_beat(logic two, logic three, logic four);
            dpcp_pkg::press_code_t e;
            if (expected_pulses.size() == 0)
            begin
                report_mismatch("output beat with nothing pending");
                return;
            end
            e = expected_pulses.pop_front();
            if (two !== (e == dpcp_pkg::CODE_TWO))
                report_mismatch($sformatf("out_two_press %b, want %b",
                                          two, e == dpcp_pkg::CODE_TWO));
            if (three !== (e == dpcp_pkg::CODE_THREE))
                report_mismatch($sformatf("out_three_press %b, want %b",
                                          three, e == dpcp_pkg::CODE_THREE));
            if (four !== (e == dpcp_pkg::CODE_FOUR))
                report_mismatch($sformatf("out_four_press %b, want %b",
                                          four, e == dpcp_pkg::CODE_FOUR));
            checked++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 raw_level;
    logic                 out_valid;
    logic                 out_stall;
    logic                 out_two_press;
    logic                 out_three_press;
    logic                 out_four_press;
    logic                 cfg_we;
    dpcp_pkg::cfg_index_t cfg_index;
    dpcp_pkg::cfg_word_t  cfg_data;

    pulse_tracker tracker;
    int           src_idle_pct;
    int           sink_idle_pct;
    int           cycle_count;
    int           cfg_writes;
    bit           bouncy;

    debounced_press_count_pulser dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .raw_level       (raw_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_two_press   (out_two_press),
        .out_three_press (out_three_press),
        .out_four_press  (out_four_press),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("debounced_press_count_pulser_test failed");
            $finish;
        end
    end

    // output beats are checked before the input beat of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_beat(out_two_press, out_three_press, out_four_press);
            if (in_valid && !in_stall)
                tracker.note_tick(raw_level);
            if (cfg_we)
            begin
                tracker.write_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task send_tick(bit lvl);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        raw_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task bounce();
        if (bouncy)
            repeat ($urandom_range(0, 5)) send_tick(bit'($urandom_range(0, 1)));
    endtask

    task press_train(int n);
        repeat (n)
        begin
            bounce();
            repeat (8 + $urandom_range(0, 3)) send_tick(1'b1);
            bounce();
            repeat (8 + $urandom_range(0, 3)) send_tick(1'b0);
        end
    endtask

    // run out the window and any hold; samples during a hold are ignored anyway
    task settle();
        while (tracker.busy())
            send_tick(tracker.holding() ? bit'($urandom_range(0, 1)) : 1'b0);
    endtask

    task set_config(dpcp_pkg::cfg_word_t window, dpcp_pkg::cfg_word_t hold_long,
                    dpcp_pkg::cfg_word_t hold_short);
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= dpcp_pkg::REG_WINDOW_TICKS;
        cfg_data  <= window;
        @(negedge clk);
        cfg_index <= dpcp_pkg::REG_HOLD_TICKS_LONG;
        cfg_data  <= hold_long;
        @(negedge clk);
        cfg_index <= dpcp_pkg::REG_HOLD_TICKS_SHORT;
        cfg_data  <= hold_short;
        @(negedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= dpcp_pkg::cfg_word_t'($urandom_range(0, 65535));
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task random_config();
        dpcp_pkg::cfg_word_t window;
        window = ($urandom_range(0, 3) == 0) ? dpcp_pkg::cfg_word_t'($urandom_range(1, 15))
                                             : dpcp_pkg::cfg_word_t'($urandom_range(20, 60));
        set_config(window, dpcp_pkg::cfg_word_t'($urandom_range(1, 40)),
                   dpcp_pkg::cfg_word_t'($urandom_range(1, 40)));
    endtask

    task random_ticks(int target);
        int start;
        int r;
        int n;
        start = tracker.live_ticks;
        while (tracker.live_ticks - start < target)
        begin
            bouncy = bit'($urandom_range(0, 1));
            r = $urandom_range(0, 9);
            if (r < 2)
                repeat ($urandom_range(1, 40)) send_tick(bit'($urandom_range(0, 1)));
            else
            begin
                r = $urandom_range(0, 9);
                case (r)
                    0:       n = 1;
                    1, 2:    n = 2;
                    3, 4:    n = 3;
                    5, 6:    n = 4;
                    7:       n = 5;
                    8:       n = 6;
                    default: n = 7;
                endcase
                press_train(n);
                if ($urandom_range(0, 3) != 0)
                    settle();
            end
        end
    endtask

    initial
    begin
        tracker       = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        raw_level     = 1'b0;
        out_stall     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = dpcp_pkg::REG_WINDOW_TICKS;
        cfg_data      = '0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        cycle_count   = 0;
        cfg_writes    = 0;
        bouncy        = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        src_idle_pct  = 6;
        sink_idle_pct = 67;

        // two presses stay open under the reset window, then one-tick holds
        press_train(2);
        set_config(16'd30, 16'd1, 16'd1);
        settle();
        press_train(3);
        settle();
        press_train(4);
        settle();

        src_idle_pct  = 67;
        sink_idle_pct = 6;

        // five presses give nothing
        press_train(5);
        settle();

        // zero window judges every count at once
        set_config(16'd0, 16'd10, 16'd10);
        press_train(2);
        settle();

        // zero holds: no pulse, count still clears
        set_config(16'd30, 16'd0, 16'd0);
        press_train(2);
        settle();
        press_train(4);
        settle();

        // widest window, then lowered under the running timer
        set_config(dpcp_pkg::TIMER_MAX, 16'd3, 16'd3);
        press_train(2);
        set_config(16'd1, 16'd3, 16'd3);
        settle();

        src_idle_pct  = 0;
        sink_idle_pct = 0;

        repeat (2)
        begin
            random_config();
            random_ticks(RANDOM_ITEMS);
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        $display("checked %0d output beats, %0d live ticks, %0d register writes",
                 tracker.checked, tracker.live_ticks, cfg_writes);
        $display("pulses started: two %0d, three %0d, four %0d; mismatches %0d",
                 tracker.pulses[dpcp_pkg::CODE_TWO], tracker.pulses[dpcp_pkg::CODE_THREE],
                 tracker.pulses[dpcp_pkg::CODE_FOUR], tracker.errors);
        if (tracker.errors == 0)
            $display("debounced_press_count_pulser_test passed");
        else
            $display("debounced_press_count_pulser_test failed");
        $finish;
    end

endmodule
